FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion helpers. They compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error(msg);

// Condition that must never be seen on a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk_sig, rst_sig, cond, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) !(cond)) \
        else $error(msg);

`else

`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg)
`define ASSERT_NEVER(label, clk_sig, rst_sig, cond, msg)

`endif

`endif

FILE: rtl/md5_pkg.sv
// ----------------------------------------------------------------------------
// MD5 package
// Item types, sequencer codes, round constants and message schedule.
// ----------------------------------------------------------------------------
package md5_pkg;

    typedef logic [31:0] word_t;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  valid_bytes;
        logic        last_item;
    } msg_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } dig_item_t;

    // Working registers a, b, c, d of the compression
    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } round_state_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_MK,
        S_ROUND,
        S_FOLD,
        S_EMIT
    } seq_state_t;

    // Which trailer word goes out next during padding
    typedef enum logic [1:0] {
        PAD_MARK,
        PAD_ZERO,
        PAD_HI,
        PAD_DONE
    } pad_sel_t;

    localparam word_t IV0 = 32'h67452301;
    localparam word_t IV1 = 32'hefcdab89;
    localparam word_t IV2 = 32'h98badcfe;
    localparam word_t IV3 = 32'h10325476;

    localparam word_t PAD_BYTE = 32'h00000080;

    localparam logic [3:0] FILL_LAST = 4'd15;
    localparam logic [3:0] FILL_LEN  = 4'd14;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [1:0] IDX_LAST  = 2'd3;
    localparam logic [2:0] BYTES_FULL = 3'd4;

    localparam word_t K_ADD [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_AMT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // Block word used by a given round
    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [3:0] r4;
        logic [3:0] g;
        r4 = rnd[3:0];
        case (rnd[5:4])
            2'd0:    g = r4;
            2'd1:    g = (r4 << 2) + r4 + 4'd1;
            2'd2:    g = (r4 << 1) + r4 + 4'd5;
            2'd3:    g = (r4 << 3) - r4;
            default: g = r4;
        endcase
        return g;
    endfunction

endpackage

FILE: rtl/md5_round.sv
// ----------------------------------------------------------------------------
// MD5 round unit
// One compression round: boolean function, adds and rotate. The block word
// plus round constant arrives already summed.
// ----------------------------------------------------------------------------
module md5_round (
    input  md5_pkg::round_state_t cur,
    input  md5_pkg::word_t        mk,
    input  logic [5:0]            rnd,
    output md5_pkg::round_state_t nxt
);

    md5_pkg::word_t f;
    md5_pkg::word_t t;
    md5_pkg::word_t rot;
    logic [63:0]    dbl;
    logic [4:0]     shamt;

    always_comb
    begin
        case (rnd[5:4])
            2'd0:    f = cur.d ^ (cur.b & (cur.c ^ cur.d));
            2'd1:    f = cur.c ^ (cur.d & (cur.b ^ cur.c));
            2'd2:    f = cur.b ^ cur.c ^ cur.d;
            2'd3:    f = cur.c ^ (cur.b | ~cur.d);
            default: f = '0;
        endcase
    end

    assign t     = cur.a + f + mk;
    assign shamt = md5_pkg::ROT_AMT[{rnd[5:4], rnd[1:0]}];
    assign dbl   = {t, t} << shamt;
    assign rot   = dbl[63:32];

    assign nxt.a = cur.d;
    assign nxt.b = cur.b + rot;
    assign nxt.c = cur.b;
    assign nxt.d = cur.c;

endmodule

FILE: rtl/md5_message_digest.sv
// ----------------------------------------------------------------------------
// MD5 message digest
// Hashes one message per run, little-endian words in, four digest words out.
// ----------------------------------------------------------------------------
//  channel | payload     | handshake              | direction
//  msg     | msg_item_t  | msg_valid / msg_ready  | message words in
//  dig     | dig_item_t  | dig_valid / dig_ready  | digest words out
//
//  Message words are taken while the sequencer is idle. Each full 16-word
//  block then passes through a setup state, the 64 rounds on the shared round
//  unit and a fold state, and no message word is taken until it is done.
//  The last item adds padding words and one or two compressions,
//  then four digest words leave, one per accepted output cycle.
//  msg_ready is high only when the sequencer is idle. No clearing pass after
//  reset; the first item may arrive on the first cycle out of reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module md5_message_digest (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 msg_valid,
    output logic                 msg_ready,
    input  md5_pkg::msg_item_t   msg_item,
    output logic                 dig_valid,
    input  logic                 dig_ready,
    output md5_pkg::dig_item_t   dig_item
);

    md5_pkg::seq_state_t   state_reg, state_next;
    md5_pkg::pad_sel_t     pad_sel_reg, pad_sel_next;
    logic [3:0]            fill_reg, fill_next;
    logic [63:0]           blen_reg, blen_next;
    logic                  fin_reg, fin_next;
    md5_pkg::word_t        pad_word_reg, pad_word_next;
    logic [5:0]            round_cnt_reg, round_cnt_next;
    md5_pkg::round_state_t round_reg, round_next;
    md5_pkg::word_t        chain_reg [4];
    md5_pkg::word_t        chain_next [4];
    md5_pkg::word_t        mk_reg, mk_next;
    logic [1:0]            idx_reg, idx_next;

    md5_pkg::word_t        store_reg [16];
    logic                  store_we;
    md5_pkg::word_t        store_wdata;

    md5_pkg::round_state_t round_out;
    logic [5:0]            mk_rnd;
    logic [2:0]            nbytes;
    logic [63:0]           bit_len;
    logic                  msg_fire;
    logic                  dig_fire;

    md5_round u_round (
        .cur (round_reg),
        .mk  (mk_reg),
        .rnd (round_cnt_reg),
        .nxt (round_out)
    );

    assign msg_ready = (state_reg == md5_pkg::S_IDLE);
    assign msg_fire  = msg_valid && msg_ready;
    assign dig_valid = (state_reg == md5_pkg::S_EMIT);
    assign dig_fire  = dig_valid && dig_ready;

    assign dig_item.digest_word = chain_reg[idx_reg];
    assign dig_item.word_index  = idx_reg;
    assign dig_item.last_word   = (idx_reg == md5_pkg::IDX_LAST);

    assign bit_len = {blen_reg[60:0], 3'b000};
    assign nbytes  = (msg_item.valid_bytes inside {[3'd5:3'd7]}) ? md5_pkg::BYTES_FULL
                                                               : msg_item.valid_bytes;

    // Block word plus constant for the round after the current one
    assign mk_rnd  = (state_reg == md5_pkg::S_ROUND) ? round_cnt_reg + 6'd1 : 6'd0;
    assign mk_next = store_reg[md5_pkg::msg_index(mk_rnd)] + md5_pkg::K_ADD[mk_rnd];

    always_comb
    begin
        state_next     = state_reg;
        pad_sel_next   = pad_sel_reg;
        fill_next      = fill_reg;
        blen_next      = blen_reg;
        fin_next       = fin_reg;
        pad_word_next  = pad_word_reg;
        round_cnt_next = round_cnt_reg;
        round_next     = round_reg;
        chain_next     = chain_reg;
        idx_next       = idx_reg;
        store_we       = 1'b0;
        store_wdata    = msg_item.data_word;

        case (state_reg)
            md5_pkg::S_IDLE:
            begin
                if (msg_fire)
                begin
                    if (!msg_item.last_item)
                    begin
                        store_we   = 1'b1;
                        fill_next  = fill_reg + 4'd1;
                        blen_next  = blen_reg + 64'd4;
                        state_next = (fill_reg == md5_pkg::FILL_LAST) ? md5_pkg::S_MK
                                                                      : md5_pkg::S_IDLE;
                    end
                    else
                    begin
                        blen_next    = blen_reg + {61'd0, nbytes};
                        fin_next     = 1'b1;
                        pad_sel_next = md5_pkg::PAD_MARK;
                        case (nbytes)
                            3'd1:    pad_word_next = {16'd0, 8'h80, msg_item.data_word[7:0]};
                            3'd2:    pad_word_next = {8'd0, 8'h80, msg_item.data_word[15:0]};
                            3'd3:    pad_word_next = {8'h80, msg_item.data_word[23:0]};
                            default: pad_word_next = md5_pkg::PAD_BYTE;
                        endcase
                        if (nbytes == md5_pkg::BYTES_FULL)
                        begin
                            store_we   = 1'b1;
                            fill_next  = fill_reg + 4'd1;
                            state_next = (fill_reg == md5_pkg::FILL_LAST) ? md5_pkg::S_MK
                                                                          : md5_pkg::S_PAD;
                        end
                        else
                        begin
                            state_next = md5_pkg::S_PAD;
                        end
                    end
                end
            end

            md5_pkg::S_PAD:
            begin
                store_we  = 1'b1;
                fill_next = fill_reg + 4'd1;
                case (pad_sel_reg)
                    md5_pkg::PAD_MARK:
                    begin
                        store_wdata  = pad_word_reg;
                        pad_sel_next = md5_pkg::PAD_ZERO;
                    end
                    md5_pkg::PAD_ZERO:
                    begin
                        if (fill_reg == md5_pkg::FILL_LEN)
                        begin
                            store_wdata  = bit_len[31:0];
                            pad_sel_next = md5_pkg::PAD_HI;
                        end
                        else
                        begin
                            store_wdata = '0;
                        end
                    end
                    md5_pkg::PAD_HI:
                    begin
                        store_wdata  = bit_len[63:32];
                        pad_sel_next = md5_pkg::PAD_DONE;
                    end
                    default:
                    begin
                        store_wdata = '0;
                    end
                endcase
                state_next = (fill_reg == md5_pkg::FILL_LAST) ? md5_pkg::S_MK
                                                              : md5_pkg::S_PAD;
            end

            md5_pkg::S_MK:
            begin
                round_next     = '{a: chain_reg[0], b: chain_reg[1],
                                   c: chain_reg[2], d: chain_reg[3]};
                round_cnt_next = '0;
                state_next     = md5_pkg::S_ROUND;
            end

            md5_pkg::S_ROUND:
            begin
                round_next     = round_out;
                round_cnt_next = round_cnt_reg + 6'd1;
                if (round_cnt_reg == md5_pkg::ROUND_LAST)
                begin
                    state_next = md5_pkg::S_FOLD;
                end
            end

            md5_pkg::S_FOLD:
            begin
                chain_next[0] = chain_reg[0] + round_reg.a;
                chain_next[1] = chain_reg[1] + round_reg.b;
                chain_next[2] = chain_reg[2] + round_reg.c;
                chain_next[3] = chain_reg[3] + round_reg.d;
                idx_next      = '0;
                if (pad_sel_reg == md5_pkg::PAD_DONE)
                begin
                    state_next = md5_pkg::S_EMIT;
                end
                else if (fin_reg)
                begin
                    state_next = md5_pkg::S_PAD;
                end
                else
                begin
                    state_next = md5_pkg::S_IDLE;
                end
            end

            md5_pkg::S_EMIT:
            begin
                if (dig_fire)
                begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == md5_pkg::IDX_LAST)
                    begin
                        chain_next   = '{md5_pkg::IV0, md5_pkg::IV1,
                                         md5_pkg::IV2, md5_pkg::IV3};
                        fill_next    = '0;
                        blen_next    = '0;
                        fin_next     = 1'b0;
                        pad_sel_next = md5_pkg::PAD_MARK;
                        state_next   = md5_pkg::S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = md5_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= md5_pkg::S_IDLE;
            pad_sel_reg   <= md5_pkg::PAD_MARK;
            fill_reg      <= '0;
            blen_reg      <= '0;
            fin_reg       <= 1'b0;
            round_cnt_reg <= '0;
            round_reg     <= '0;
            chain_reg     <= '{md5_pkg::IV0, md5_pkg::IV1, md5_pkg::IV2, md5_pkg::IV3};
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pad_sel_reg   <= pad_sel_next;
            fill_reg      <= fill_next;
            blen_reg      <= blen_next;
            fin_reg       <= fin_next;
            round_cnt_reg <= round_cnt_next;
            round_reg     <= round_next;
            chain_reg     <= chain_next;
            idx_reg       <= idx_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        pad_word_reg <= pad_word_next;
        mk_reg       <= mk_next;
        if (store_we)
        begin
            store_reg[fill_reg] <= store_wdata;
        end
    end

    `ASSERT_CLK(a_round_to_fold, clk, rst_n,
        (state_reg == md5_pkg::S_ROUND && round_cnt_reg == md5_pkg::ROUND_LAST)
            |=> (state_reg == md5_pkg::S_FOLD), "compression did not end after 64 rounds")
    `ASSERT_CLK(a_emit_restarts, clk, rst_n,
        (dig_fire && dig_item.last_word)
            |=> (chain_reg[0] == md5_pkg::IV0 && fill_reg == '0 && blen_reg == '0),
        "state not returned to initial vector after digest")
    `ASSERT_NEVER(a_idle_no_pad, clk, rst_n, msg_ready && fin_reg,
        "idle with an unfinished trailer")
    `ASSERT_NEVER(a_emit_block_empty, clk, rst_n, dig_valid && (fill_reg != '0),
        "digest shown with a partial block held")

endmodule

FILE: verif/md5_message_digest_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MD5 message digest testbench
// Streams directed and random messages through the block, with random gaps
// on the message side and random stalls on the digest side. A local MD5
// tracker predicts the four digest words of each message. Every digest word
// that leaves the block is checked field by field against the prediction.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned RAND_ITEMS  = 80;

    localparam md5_pkg::word_t INIT_A = 32'h67452301;
    localparam md5_pkg::word_t INIT_B = 32'hefcdab89;
    localparam md5_pkg::word_t INIT_C = 32'h98badcfe;
    localparam md5_pkg::word_t INIT_D = 32'h10325476;

    localparam md5_pkg::word_t SINE_ADD [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int unsigned SHIFT_AMT [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    // Running MD5 of the current message and the digest words it owes
    class digest_tracker;
        md5_pkg::word_t     chain [4];
        md5_pkg::word_t     blk [16];
        int unsigned        fill;
        logic [63:0]        msg_bytes;
        md5_pkg::dig_item_t digest_q [$];
        int unsigned        errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            chain[0]  = INIT_A;
            chain[1]  = INIT_B;
            chain[2]  = INIT_C;
            chain[3]  = INIT_D;
            fill      = 0;
            msg_bytes = '0;
        endfunction

        function int unsigned pending();
            return digest_q.size();
        endfunction

        function void compress_block();
            md5_pkg::word_t a, b, c, d, f, t;
            int unsigned    g, quarter, s;
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            for (int r = 0; r < 64; r++)
            begin
                quarter = r / 16;
                case (quarter)
                    0:
                    begin
                        f = (b & c) | (~b & d);
                        g = r;
                    end
                    1:
                    begin
                        f = (b & d) | (c & ~d);
                        g = (5 * r + 1) % 16;
                    end
                    2:
                    begin
                        f = b ^ c ^ d;
                        g = (3 * r + 5) % 16;
                    end
                    default:
                    begin
                        f = c ^ (b | ~d);
                        g = (7 * r) % 16;
                    end
                endcase
                t = a + f + blk[g] + SINE_ADD[r];
                s = SHIFT_AMT[quarter * 4 + r % 4];
                a = d;
                d = c;
                c = b;
                b = b + ((t << s) | (t >> (32 - s)));
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
        endfunction

        function void push_word(input md5_pkg::word_t w);
            blk[fill] = w;
            fill = (fill + 1) % 16;
            if (fill == 0)
                compress_block();
        endfunction

        function void note_message_word(input md5_pkg::msg_item_t it);
            int unsigned        n;
            md5_pkg::word_t     tail;
            logic [63:0]        bit_len;
            md5_pkg::dig_item_t want;
            // inner words always carry four bytes
            if (!it.last_item)
            begin
                msg_bytes += 4;
                push_word(it.data_word);
                return;
            end
            n = (it.valid_bytes > 3'd4) ? 4 : it.valid_bytes;
            msg_bytes += n;
            if (n == 4)
            begin
                push_word(it.data_word);
                tail = 32'h80;
            end
            else if (n == 0)
                tail = 32'h80;
            else
                tail = (it.data_word & (32'hffffffff >> (32 - 8 * n))) | (32'h80 << (8 * n));
            push_word(tail);
            // no room for the length: zero-fill into an extra block
            if (fill > 14)
                while (fill != 0)
                    push_word('0);
            while (fill < 14)
                push_word('0);
            bit_len = msg_bytes << 3;
            push_word(bit_len[31:0]);
            push_word(bit_len[63:32]);
            for (int k = 0; k < 4; k++)
            begin
                want.digest_word = chain[k];
                want.word_index  = 2'(k);
                want.last_word   = (k == 3);
                digest_q.push_back(want);
            end
            restart();
        endfunction

        function void check_digest_word(input md5_pkg::dig_item_t got);
            md5_pkg::dig_item_t want;
            if (digest_q.size() == 0)
            begin
                $error("digest item with nothing expected: word %h index %0d last %0b",
                       got.digest_word, got.word_index, got.last_word);
                errors++;
                return;
            end
            want = digest_q.pop_front();
            if (got.digest_word !== want.digest_word)
            begin
                $error("digest_word: expected %h, got %h", want.digest_word, got.digest_word);
                errors++;
            end
            if (got.word_index !== want.word_index)
            begin
                $error("word_index: expected %0d, got %0d", want.word_index, got.word_index);
                errors++;
            end
            if (got.last_word !== want.last_word)
            begin
                $error("last_word: expected %0b, got %0b", want.last_word, got.last_word);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               msg_valid;
    logic               msg_ready;
    md5_pkg::msg_item_t msg_item;
    logic               dig_valid;
    logic               dig_ready;
    md5_pkg::dig_item_t dig_item;

    digest_tracker tracker;
    int unsigned   msg_gap_pct;
    int unsigned   dig_stall_pct;
    int unsigned   sent_items;
    int unsigned   sent_messages;
    int unsigned   quiet_cycles;

    md5_message_digest dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_ready (msg_ready),
        .msg_item  (msg_item),
        .dig_valid (dig_valid),
        .dig_ready (dig_ready),
        .dig_item  (dig_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // monitors sample at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (msg_valid && msg_ready)
                tracker.note_message_word(msg_item);
            if (dig_valid && dig_ready)
                tracker.check_digest_word(dig_item);
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            dig_ready <= ($urandom_range(99) >= dig_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((msg_valid && msg_ready) || (dig_valid && dig_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_item(input md5_pkg::msg_item_t it);
        @(negedge clk);
        if ($urandom_range(99) < msg_gap_pct)
        begin
            msg_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < msg_gap_pct);
        end
        msg_valid <= 1'b1;
        msg_item  <= it;
        do
            @(posedge clk);
        while (!msg_ready);
        sent_items++;
    endtask

    task automatic send_message(input int unsigned body_words, input logic [2:0] tail_bytes);
        md5_pkg::msg_item_t it;
        for (int i = 0; i < body_words; i++)
        begin
            it.data_word   = $urandom();
            // inner words ignore the byte count, so scramble it now and then
            it.valid_bytes = ($urandom_range(3) == 0) ? 3'($urandom_range(7))
                                                      : md5_pkg::BYTES_FULL;
            it.last_item   = 1'b0;
            send_item(it);
        end
        it.data_word   = $urandom();
        it.valid_bytes = tail_bytes;
        it.last_item   = 1'b1;
        send_item(it);
        sent_messages++;
    endtask

    // sender goes idle first so the accepted item is not offered again
    task automatic wait_drained();
        @(negedge clk);
        msg_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned pick;
        int unsigned body;
        int unsigned rand_start;
        int unsigned phase;

        tracker       = new();
        rst_n         = 1'b0;
        msg_valid     = 1'b0;
        msg_item      = '0;
        dig_ready     = 1'b0;
        msg_gap_pct   = 17;
        dig_stall_pct = 69;
        sent_items    = 0;
        sent_messages = 0;
        quiet_cycles  = 0;
        phase         = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty message, partial tails with ones above the valid bytes,
        // full tails at both data extremes, oversized byte counts
        send_item('{data_word: 32'h00000000, valid_bytes: 3'd0, last_item: 1'b1});
        send_item('{data_word: 32'hffffffff, valid_bytes: 3'd1, last_item: 1'b1});
        send_item('{data_word: 32'hffffffff, valid_bytes: 3'd2, last_item: 1'b1});
        send_item('{data_word: 32'hffffffff, valid_bytes: 3'd3, last_item: 1'b1});
        send_item('{data_word: 32'h00000000, valid_bytes: 3'd4, last_item: 1'b1});
        send_item('{data_word: 32'hffffffff, valid_bytes: 3'd4, last_item: 1'b1});
        send_item('{data_word: 32'ha5a5a5a5, valid_bytes: 3'd5, last_item: 1'b1});
        send_item('{data_word: 32'h5a5a5a5a, valid_bytes: 3'd6, last_item: 1'b1});
        send_item('{data_word: 32'hffffffff, valid_bytes: 3'd7, last_item: 1'b1});
        // inner words with odd byte counts still carry four bytes
        send_item('{data_word: 32'hffffffff, valid_bytes: 3'd0, last_item: 1'b0});
        send_item('{data_word: 32'h00000000, valid_bytes: 3'd7, last_item: 1'b0});
        send_item('{data_word: 32'h12345678, valid_bytes: 3'd3, last_item: 1'b1});
        // length no longer fits: two final compressions
        send_message(13, md5_pkg::BYTES_FULL);

        rand_start = sent_items;
        while (sent_items - rand_start < RAND_ITEMS)
        begin
            if (phase == 0 && sent_items - rand_start >= RAND_ITEMS / 3)
            begin
                wait_drained();
                msg_gap_pct   = 69;
                dig_stall_pct = 17;
                phase         = 1;
            end
            else if (phase == 1 && sent_items - rand_start >= 2 * RAND_ITEMS / 3)
            begin
                wait_drained();
                msg_gap_pct   = 0;
                dig_stall_pct = 0;
                phase         = 2;
            end
            pick = $urandom_range(9);
            if (pick < 6)
                body = $urandom_range(6);
            else if (pick < 8)
                body = 12 + $urandom_range(4);
            else
                body = 16 + $urandom_range(24);
            send_message(body, 3'($urandom_range(7)));
        end

        wait_drained();
        repeat (100) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
